// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the cycle after reset is applied
`define CMI_ASSERT_AFTER_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) (rst) |=> (prop)) \
    else $error("cmi: post-reset check failed");

// antecedent in this cycle implies property in the next, off during reset
`define CMI_ASSERT_NEXT(label, clk, rst, ante, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (prop)) \
    else $error("cmi: next-cycle check failed");

`endif

// File: rtl/core/cmi_pkg.sv
// ----------------------------------------------------------------------------
// cmi_pkg
// Shared constants and codes for the colormap interpolation block.
// ----------------------------------------------------------------------------
package cmi_pkg;

  // default sizing
  localparam int DEF_MAX_ENTRIES  = 512;
  localparam int DEF_CHANNEL_BITS = 8;
  localparam int DEF_SAMPLE_BITS  = 16;

  // normalized position: Q0.16 plus one bit so that 1.0 is exact
  localparam int T_FRAC_BITS = 16;
  localparam int T_BITS      = T_FRAC_BITS + 1;

  // smallest usable palette size
  localparam int COUNT_MIN = 2;

  // words held between front and back
  localparam int QUEUE_DEPTH = 4;

  // item operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_LOW   = 2'd0,
    CFG_RANGE_HIGH  = 2'd1,
    CFG_ENTRY_COUNT = 2'd2
  } cfg_reg_t;

endpackage

// File: rtl/core/cmi_channels.sv
// ----------------------------------------------------------------------------
// cmi_channels
// Valid/ready channels: command words in, color words out.
// ----------------------------------------------------------------------------
interface cmi_cmd_if import cmi_pkg::*; #(
  parameter int SLOT_W       = $clog2(DEF_MAX_ENTRIES),
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [SLOT_W-1:0]             entry_slot;
  logic [CHANNEL_BITS-1:0]       entry_red;
  logic [CHANNEL_BITS-1:0]       entry_green;
  logic [CHANNEL_BITS-1:0]       entry_blue;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, operation, entry_slot, entry_red, entry_green,
                  entry_blue, sample, input ready);
  modport sink   (input valid, operation, entry_slot, entry_red, entry_green,
                  entry_blue, sample, output ready);
endinterface

interface cmi_pix_if import cmi_pkg::*; #(
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;
  logic                    range_error;

  modport source (output valid, red, green, blue, range_error, input ready);
  modport sink   (input valid, red, green, blue, range_error, output ready);
endinterface

// File: rtl/core/cmi_queue.sv
// ----------------------------------------------------------------------------
// cmi_queue
// Small FIFO that decouples the front pipeline from the back pipeline.
// ----------------------------------------------------------------------------
module cmi_queue import cmi_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/core/cmi_front.sv
// ----------------------------------------------------------------------------
// cmi_front
// Accepts command words, classifies them against the configured range and
// runs the pipelined divider that yields the normalized position t.
// ----------------------------------------------------------------------------
module cmi_front import cmi_pkg::*; #(
  parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  localparam int IDX_W  = $clog2(MAX_ENTRIES),
  localparam int ITEM_W = 2 + IDX_W + 3 * CHANNEL_BITS + T_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  cmi_cmd_if.sink                       cmd,
  input  logic signed [SAMPLE_BITS-1:0] range_low,
  input  logic signed [SAMPLE_BITS-1:0] range_high,
  input  logic                          q_full,
  output logic                          push,
  output logic [ITEM_W-1:0]             push_data
);

  localparam int NSTG = T_FRAC_BITS;

  // one divider stage's contents
  typedef struct packed {
    logic                    is_load;
    logic [IDX_W-1:0]        slot;
    logic [CHANNEL_BITS-1:0] r;
    logic [CHANNEL_BITS-1:0] g;
    logic [CHANNEL_BITS-1:0] b;
    logic                    err;
    logic                    sat;
    logic                    divide;
    logic [SAMPLE_BITS-1:0]  rem;
    logic [SAMPLE_BITS-1:0]  span;
    logic [T_FRAC_BITS-1:0]  quo;
  } stage_t;

  // word handed to the back end
  typedef struct packed {
    logic                    is_load;
    logic [IDX_W-1:0]        slot;
    logic [CHANNEL_BITS-1:0] r;
    logic [CHANNEL_BITS-1:0] g;
    logic [CHANNEL_BITS-1:0] b;
    logic                    err;
    logic [T_BITS-1:0]       t;
  } item_t;

  logic   vld [0:NSTG];
  stage_t st  [0:NSTG];
  stage_t st_d [0:NSTG];
  stage_t cls;
  logic   adv;
  item_t  item;

  // whole pipe moves unless the last word cannot enter the queue
  assign adv       = !vld[NSTG] || !q_full;
  assign cmd.ready = adv;
  assign push      = vld[NSTG] && !q_full;

  // classify: range check, clamp, and divider operands
  always_comb begin
    logic signed [SAMPLE_BITS:0] smp_x;
    logic signed [SAMPLE_BITS:0] low_x;
    logic signed [SAMPLE_BITS:0] high_x;
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [SAMPLE_BITS:0] span;
    logic                        zero;
    smp_x  = {cmd.sample[SAMPLE_BITS-1], cmd.sample};
    low_x  = {range_low[SAMPLE_BITS-1], range_low};
    high_x = {range_high[SAMPLE_BITS-1], range_high};
    diff   = smp_x - low_x;
    span   = high_x - low_x;

    cls.is_load = (cmd.operation == OP_LOAD);
    cls.slot    = cmd.entry_slot;
    cls.r       = cmd.entry_red;
    cls.g       = cmd.entry_green;
    cls.b       = cmd.entry_blue;
    cls.err     = span[SAMPLE_BITS] || (span == '0);
    zero        = cls.err || diff[SAMPLE_BITS] || (diff == '0);
    cls.sat     = !zero && (diff >= span);
    cls.divide  = !zero && !cls.sat;
    cls.rem     = diff[SAMPLE_BITS-1:0];
    cls.span    = span[SAMPLE_BITS-1:0];
    cls.quo     = '0;
  end

  // restoring divider: one quotient bit per stage
  always_comb begin
    logic [SAMPLE_BITS:0] shf;
    logic [SAMPLE_BITS:0] sub;
    st_d[0] = cls;
    for (int k = 1; k <= NSTG; k++) begin
      st_d[k] = st[k-1];
      shf     = {st[k-1].rem, 1'b0};
      sub     = shf - {1'b0, st[k-1].span};
      if (shf >= {1'b0, st[k-1].span}) begin
        st_d[k].rem = sub[SAMPLE_BITS-1:0];
        st_d[k].quo = {st[k-1].quo[T_FRAC_BITS-2:0], 1'b1};
      end else begin
        st_d[k].rem = shf[SAMPLE_BITS-1:0];
        st_d[k].quo = {st[k-1].quo[T_FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NSTG; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= cmd.valid;
      for (int k = 1; k <= NSTG; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= NSTG; k++) begin
        st[k] <= st_d[k];
      end
    end
  end

  // final position: 0, exactly 1.0, or the quotient
  always_comb begin
    item.is_load = st[NSTG].is_load;
    item.slot    = st[NSTG].slot;
    item.r       = st[NSTG].r;
    item.g       = st[NSTG].g;
    item.b       = st[NSTG].b;
    item.err     = st[NSTG].err;
    if (st[NSTG].sat) begin
      item.t = {1'b1, {T_FRAC_BITS{1'b0}}};
    end else if (st[NSTG].divide) begin
      item.t = {1'b0, st[NSTG].quo};
    end else begin
      item.t = '0;
    end
  end

  assign push_data = item;

endmodule

// File: rtl/core/cmi_back.sv
// ----------------------------------------------------------------------------
// cmi_back
// Scales t by (palette size - 1), reads two neighboring entries, blends them
// and holds the color word in the output register. Loads write the palette.
// ----------------------------------------------------------------------------
module cmi_back import cmi_pkg::*; #(
  parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  localparam int IDX_W   = $clog2(MAX_ENTRIES),
  localparam int COUNT_W = $clog2(MAX_ENTRIES + 1),
  localparam int CFG_W   = (SAMPLE_BITS > COUNT_W) ? SAMPLE_BITS : COUNT_W,
  localparam int ITEM_W  = 2 + IDX_W + 3 * CHANNEL_BITS + T_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CFG_W-1:0]  entry_count,
  input  logic              q_empty,
  input  logic [ITEM_W-1:0] q_data,
  output logic              pop,
  cmi_pix_if.source         pix
);

  localparam int P_W   = T_BITS + IDX_W;
  localparam int RGB_W = 3 * CHANNEL_BITS;
  localparam int ACC_W = CHANNEL_BITS + T_FRAC_BITS + 2;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (T_FRAC_BITS - 1);

  typedef struct packed {
    logic                    is_load;
    logic [IDX_W-1:0]        slot;
    logic [CHANNEL_BITS-1:0] r;
    logic [CHANNEL_BITS-1:0] g;
    logic [CHANNEL_BITS-1:0] b;
    logic                    err;
    logic [T_BITS-1:0]       t;
  } item_t;

  item_t q_item;
  logic  en;

  // stage 1: product
  logic             vld1;
  logic             load1;
  logic [IDX_W-1:0] slot1;
  logic [RGB_W-1:0] rgb1;
  logic             err1;
  logic [P_W-1:0]   p1;

  // stage 2: palette read
  logic             vld2;
  logic             err2;
  logic [T_FRAC_BITS-1:0] frac2;
  logic [RGB_W-1:0] rd_a;
  logic [RGB_W-1:0] rd_b;

  // stage 3: blend products
  logic                    vld3;
  logic                    err3;
  logic [CHANNEL_BITS-1:0] base3 [3];
  logic signed [ACC_W-1:0] prod3 [3];

  // output register
  logic                    out_vld;
  logic                    out_err;
  logic [CHANNEL_BITS-1:0] out_c [3];

  logic [COUNT_W-1:0]      cnt_eff;
  logic [COUNT_W-1:0]      cnt_m1;
  logic [IDX_W-1:0]        idx2;
  logic [IDX_W-1:0]        idx2_b;
  logic [T_FRAC_BITS-1:0]  frac1;
  logic                    wr_ok;
  logic signed [ACC_W-1:0] prod_d [3];
  logic [CHANNEL_BITS-1:0] res_d [3];

  logic [RGB_W-1:0] pal_mem [MAX_ENTRIES];

  assign q_item = item_t'(q_data);
  assign en     = !out_vld || pix.ready;
  assign pop    = en && !q_empty;

  // clamp the palette size into its legal range
  always_comb begin
    if (entry_count < CFG_W'(COUNT_MIN)) begin
      cnt_eff = COUNT_W'(COUNT_MIN);
    end else if (entry_count > CFG_W'(MAX_ENTRIES)) begin
      cnt_eff = COUNT_W'(MAX_ENTRIES);
    end else begin
      cnt_eff = entry_count[COUNT_W-1:0];
    end
    cnt_m1 = cnt_eff - COUNT_W'(1);
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (en) begin
      load1 <= q_item.is_load;
      slot1 <= q_item.slot;
      rgb1  <= {q_item.r, q_item.g, q_item.b};
      err1  <= q_item.err;
      p1    <= P_W'(q_item.t) * P_W'(cnt_m1[IDX_W-1:0]);
    end
  end

  // entry index and blend weight; second entry only when blending
  assign idx2   = p1[T_FRAC_BITS +: IDX_W];
  assign frac1  = p1[T_FRAC_BITS-1:0];
  assign idx2_b = (frac1 != '0) ? idx2 + 1'b1 : idx2;
  assign wr_ok  = vld1 && load1 && ({1'b0, slot1} < (IDX_W + 1)'(MAX_ENTRIES));

  // palette: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (en) begin
      if (wr_ok) begin
        pal_mem[slot1] <= rgb1;
      end
      rd_a <= pal_mem[idx2];
      rd_b <= pal_mem[idx2_b];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err2  <= err1;
      frac2 <= frac1;
    end
  end

  // blend as a + (b - a) * frac
  always_comb begin
    logic signed [CHANNEL_BITS:0] dlt;
    for (int c = 0; c < 3; c++) begin
      dlt = $signed({1'b0, rd_b[c*CHANNEL_BITS +: CHANNEL_BITS]})
          - $signed({1'b0, rd_a[c*CHANNEL_BITS +: CHANNEL_BITS]});
      prod_d[c] = dlt * $signed({1'b0, frac2});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err3 <= err2;
      for (int c = 0; c < 3; c++) begin
        base3[c] <= rd_a[c*CHANNEL_BITS +: CHANNEL_BITS];
        prod3[c] <= prod_d[c];
      end
    end
  end

  // round to nearest and drop the fraction
  always_comb begin
    logic signed [ACC_W-1:0] acc;
    for (int c = 0; c < 3; c++) begin
      acc = $signed({2'b00, base3[c], {T_FRAC_BITS{1'b0}}}) + prod3[c] + RND;
      res_d[c] = acc[T_FRAC_BITS +: CHANNEL_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_err <= err3;
      for (int c = 0; c < 3; c++) begin
        out_c[c] <= res_d[c];
      end
    end
  end

  // valid bits; loads drop out after the palette write
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= !q_empty;
      vld2    <= vld1 && !load1;
      vld3    <= vld2;
      out_vld <= vld3;
    end
  end

  assign pix.valid       = out_vld;
  assign pix.red         = out_c[2];
  assign pix.green       = out_c[1];
  assign pix.blue        = out_c[0];
  assign pix.range_error = out_err;

endmodule

// File: rtl/core/colormap_interpolate.sv
// Throughput: one word per cycle, loads and maps alike, while pix accepts;
// 16-stage divider and 4-deep queue accept words while pix stalls until full.
// Reset: clears pipeline valid bits, queue and registers (range_low 0,
// range_high max positive, entry_count 2); palette entries are undefined
// until loaded and get no clearing pass.
// ----------------------------------------------------------------------------
// colormap_interpolate
// Maps a signed sample to an RGB color by linear interpolation between two
// neighboring entries of a loadable palette.
// ----------------------------------------------------------------------------
module colormap_interpolate import cmi_pkg::*; #(
  parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  localparam int COUNT_W = $clog2(MAX_ENTRIES + 1),
  localparam int CFG_W   = (SAMPLE_BITS > COUNT_W) ? SAMPLE_BITS : COUNT_W
) (
  input  logic                 clk,
  input  logic                 rst,
  cmi_cmd_if.sink              cmd,
  cmi_pix_if.source            pix,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int ITEM_W = 2 + IDX_W + 3 * CHANNEL_BITS + T_BITS;

  logic signed [SAMPLE_BITS-1:0] range_low;
  logic signed [SAMPLE_BITS-1:0] range_high;
  logic [CFG_W-1:0]              entry_count;

  logic              push;
  logic [ITEM_W-1:0] push_data;
  logic              q_full;
  logic              pop;
  logic [ITEM_W-1:0] pop_data;
  logic              q_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low   <= '0;
      range_high  <= {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      entry_count <= CFG_W'(COUNT_MIN);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RANGE_LOW:   range_low   <= cfg_data[SAMPLE_BITS-1:0];
        CFG_RANGE_HIGH:  range_high  <= cfg_data[SAMPLE_BITS-1:0];
        CFG_ENTRY_COUNT: entry_count <= cfg_data;
        default: ;
      endcase
    end
  end

  cmi_front #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .CHANNEL_BITS (CHANNEL_BITS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .range_low  (range_low),
    .range_high (range_high),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  cmi_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  cmi_back #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .CHANNEL_BITS (CHANNEL_BITS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_count (entry_count),
    .q_empty     (q_empty),
    .q_data      (pop_data),
    .pop         (pop),
    .pix         (pix)
  );

endmodule

// File: rtl/core/cmi_checker.sv
// ----------------------------------------------------------------------------
// cmi_checker
// Port-level checks on the colormap block, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cmi_checker #(
  parameter int WORD_W = 25
) (
  input logic              clk,
  input logic              rst,
  input logic              cmd_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_word
);

  // reset empties the pipeline: no result, input open
  `CMI_ASSERT_AFTER_RST(a_rst_no_out, clk, rst, !out_valid)
  `CMI_ASSERT_AFTER_RST(a_rst_ready, clk, rst, cmd_ready)

  // a stalled result stays and keeps its value
  `CMI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `CMI_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_word))

endmodule

bind colormap_interpolate cmi_checker #(
  .WORD_W (3 * CHANNEL_BITS + 1)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_ready (cmd.ready),
  .out_valid (pix.valid),
  .out_ready (pix.ready),
  .out_word  ({pix.red, pix.green, pix.blue, pix.range_error})
);
